// ===== design/nmf_pkg.sv =====
// Package with the shared types, codes and neighbor offset tables of the mean filter.
package nmf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam logic [1:0] JOB_LAST = 2'd3;
  localparam logic [2:0] NB_LAST  = 3'd7;
  localparam int unsigned MAX_HEIGHT = 1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JOB,
    ST_NB,
    ST_DRAIN,
    ST_DIVI,
    ST_DIV,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       load_job;
    logic [1:0] job;
    logic       rd_en;
    logic [2:0] nb;
    logic       div_init;
    logic       div_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [3:0] job_vld;
  } status_t;

  // Row offset of neighbor k as a two-bit signed value.
  function automatic logic signed [1:0] nb_di(input logic [2:0] k);
    logic signed [1:0] d;
    unique case (k)
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd3, 3'd4:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  // Column offset of neighbor k as a two-bit signed value.
  function automatic logic signed [1:0] nb_dj(input logic [2:0] k);
    logic signed [1:0] d;
    unique case (k)
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd1, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

endpackage

// ===== design/nmf_ctrl.sv =====
// Controller state machine that sequences pixel intake, neighbor reads, division and output.
module nmf_ctrl
  import nmf_pkg::*;
#(
  parameter int PIXEL_BITS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int SW = PIXEL_BITS + 11;
  localparam int DCW = $clog2(SW);

  state_t         state_r, state_nxt;
  logic [1:0]     job_r, job_nxt;
  logic [2:0]     nb_r, nb_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= '0;
      nb_r    <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      nb_r    <= nb_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    nb_nxt       = nb_r;
    dcnt_nxt     = dcnt_r;
    cmd          = '0;
    cmd.job      = job_r;
    cmd.nb       = nb_r;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          job_nxt    = '0;
          state_nxt  = ST_JOB;
        end
      end
      ST_JOB: begin
        if (status.job_vld[job_r]) begin
          cmd.load_job = 1'b1;
          nb_nxt       = '0;
          state_nxt    = ST_NB;
        end else if (job_r == JOB_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          job_nxt = job_r + 2'd1;
        end
      end
      ST_NB: begin
        cmd.rd_en = 1'b1;
        nb_nxt    = nb_r + 3'd1;
        if (nb_r == NB_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(SW - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (job_r == JOB_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            job_nxt   = job_r + 2'd1;
            state_nxt = ST_JOB;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== design/nmf_datapath.sv =====
// Datapath: configuration, raster counters, line store, accumulator and serial divider.
module nmf_datapath
  import nmf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [1:0]                   cfg_index,
  input  logic [10:0]                  cfg_data,
  input  logic signed [PIXEL_BITS-1:0] in_pixel,
  input  cmd_t                         cmd,
  output status_t                      status,
  output logic [9:0]                   out_row,
  output logic [9:0]                   out_col,
  output logic signed [23:0]           out_average,
  output logic                         out_last_of_run
);

  localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW0 = PIXEL_BITS + 3;
  localparam int SW  = SW0 + 8;

  logic [10:0]   w_r, h_r;
  logic [CW:0]   eff_w;
  logic [10:0]   eff_h;
  logic [31:0]   wx, hx;
  logic [9:0]    row_r;
  logic [CW-1:0] col_r;
  logic [1:0]    slot_r;
  logic [3:0]    flags_r;
  logic [9:0]    i_r;
  logic [CW-1:0] j_r;
  logic [1:0]    islot_r;

  logic [PIXEL_BITS-1:0] mem [0:2][0:MAX_WIDTH-1];
  logic [PIXEL_BITS-1:0] rdat_r;
  logic                  rdv_r;
  logic signed [SW0-1:0] acc_r;
  logic [3:0]            cnt_r;
  logic [SW-1:0]         quo_r;
  logic [4:0]            rem_r;
  logic                  neg_r;

  // Clamped frame size.
  always_comb begin
    wx = 32'(w_r);
    if (wx < 32'd2) wx = 32'd2;
    else if (wx > 32'(MAX_WIDTH)) wx = 32'(MAX_WIDTH);
    eff_w = wx[CW:0];
    hx = 32'(h_r);
    if (hx < 32'd2) hx = 32'd2;
    else if (hx > 32'(MAX_HEIGHT)) hx = 32'(MAX_HEIGHT);
    eff_h = hx[10:0];
  end

  // Position of the incoming pixel, restarting the frame if out of range.
  logic          wrap;
  logic [9:0]    cur_r;
  logic [CW-1:0] cur_c;
  logic [1:0]    cur_s;
  logic [CW:0]   c_inc;
  logic [10:0]   r_inc;
  always_comb begin
    wrap  = ({1'b0, row_r} >= eff_h) || ({1'b0, col_r} >= eff_w);
    cur_r = wrap ? '0 : row_r;
    cur_c = wrap ? '0 : col_r;
    cur_s = wrap ? '0 : slot_r;
    c_inc = {1'b0, cur_c} + 1'b1;
    r_inc = {1'b0, cur_r} + 11'd1;
  end

  // Configuration registers and raster counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= 11'd8;
      h_r    <= 11'd8;
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
      if (cfg_index == REG_WIDTH) w_r <= cfg_data;
      else h_r <= cfg_data;
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (cmd.accept) begin
      if (c_inc >= eff_w) begin
        col_r <= '0;
        if (r_inc >= eff_h) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= r_inc[9:0];
          slot_r <= (cur_s == 2'd2) ? 2'd0 : cur_s + 2'd1;
        end
      end else begin
        col_r <= c_inc[CW-1:0];
      end
    end
  end

  // Latch the position and the set of results this pixel releases.
  logic [CW:0] c_ext;
  always_comb begin
    c_ext = {1'b0, cur_c};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      flags_r[0] <= (cur_r != 10'd0) && (cur_c != '0);
      flags_r[1] <= (cur_r != 10'd0) && (c_ext == eff_w - 1'b1);
      flags_r[2] <= ({1'b0, cur_r} == eff_h - 11'd1) && (cur_c != '0);
      flags_r[3] <= ({1'b0, cur_r} == eff_h - 11'd1) && (c_ext == eff_w - 2'd2);
    end
  end
  assign status.job_vld = flags_r;

  // Load the position of one result.
  logic [1:0] slot_prev;
  always_comb begin
    slot_prev = (cur_s == 2'd0) ? 2'd2 : cur_s - 2'd1;
  end

  logic [9:0]    acc_row_r;
  logic [CW-1:0] acc_col_r;
  logic [1:0]    acc_slot_r, acc_pslot_r;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc_row_r   <= cur_r;
      acc_col_r   <= cur_c;
      acc_slot_r  <= cur_s;
      acc_pslot_r <= slot_prev;
    end
  end

  logic [CW:0] w_last;
  always_comb begin
    w_last = eff_w - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_job) begin
      unique case (cmd.job)
        2'd0: begin
          i_r <= acc_row_r - 10'd1; j_r <= acc_col_r - 1'b1; islot_r <= acc_pslot_r;
        end
        2'd1: begin
          i_r <= acc_row_r - 10'd1; j_r <= acc_col_r; islot_r <= acc_pslot_r;
        end
        2'd2: begin
          i_r <= acc_row_r; j_r <= acc_col_r - 1'b1; islot_r <= acc_slot_r;
        end
        default: begin
          i_r <= acc_row_r; j_r <= w_last[CW-1:0]; islot_r <= acc_slot_r;
        end
      endcase
    end
  end

  // Neighbor address and bounds check.
  logic signed [1:0]    di, dj;
  logic signed [11:0]   nr;
  logic signed [CW+1:0] nc;
  logic                 nb_ok;
  logic [1:0]           nslot;
  always_comb begin
    di    = nb_di(cmd.nb);
    dj    = nb_dj(cmd.nb);
    nr    = $signed({2'b00, i_r}) + 12'(di);
    nc    = $signed({2'b00, j_r}) + (CW+2)'(dj);
    nb_ok = (nr >= 12'sd0) && (nr < $signed({1'b0, eff_h})) &&
            (nc[CW+1] == 1'b0) && (nc < $signed({1'b0, eff_w}));
    unique case (di)
      -2'sd1:  nslot = (islot_r == 2'd0) ? 2'd2 : islot_r - 2'd1;
      2'sd0:   nslot = islot_r;
      default: nslot = (islot_r == 2'd2) ? 2'd0 : islot_r + 2'd1;
    endcase
  end

  // Line store: pixel written on intake, neighbors read one per cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[cur_s][cur_c] <= in_pixel;
    end
    if (cmd.rd_en) begin
      rdat_r <= mem[nslot][nc[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= cmd.rd_en && nb_ok;
    end
  end

  // Neighbor sum and count.
  always_ff @(posedge clk) begin
    if (cmd.load_job) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (rdv_r) begin
      acc_r <= acc_r + SW0'($signed(rdat_r));
      cnt_r <= cnt_r + 4'd1;
    end
  end

  // Restoring divider on the magnitude of sum times 256, one bit per cycle.
  logic [SW0-1:0] mag;
  logic [4:0]     trial;
  always_comb begin
    mag   = acc_r[SW0-1] ? SW0'(-acc_r) : SW0'(acc_r);
    trial = {rem_r[3:0], quo_r[SW-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r <= {mag, 8'd0};
      rem_r <= '0;
      neg_r <= acc_r[SW0-1];
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, cnt_r}) begin
        rem_r <= trial - {1'b0, cnt_r};
        quo_r <= {quo_r[SW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[SW-2:0], 1'b0};
      end
    end
  end

  // Signed, clamped result and its tags.
  logic signed [63:0] qs;
  logic [3:0]         higher;
  always_comb begin
    qs = neg_r ? -$signed({{(64-SW){1'b0}}, quo_r}) : $signed({{(64-SW){1'b0}}, quo_r});
    if (qs > 64'sd8388607) qs = 64'sd8388607;
    else if (qs < -64'sd8388608) qs = -64'sd8388608;
    out_average     = qs[23:0];
    out_row         = i_r;
    out_col         = 10'(j_r);
    higher          = 4'(4'b1110 << cmd.job);
    out_last_of_run = ((flags_r & higher) == 4'd0);
  end

endmodule

// ===== design/neighbor_mean_filter_3x3_unit.sv =====
// Top level of the 3x3 neighbor mean filter: controller and datapath.
//
// Pixels enter in raster order on the in_ channel (in_valid / in_stall); a
// transaction happens when valid is high and stall is low. Each pixel releases
// zero to three averages on the out_ channel, in raster order of their
// positions, with out_last_of_run marking the final one of a pixel.
// One pixel is handled at a time: intake, then a check of each of the four
// possible results in order. A released result adds line store reads of its
// eight neighbors (one read port), a drain and a divider setup step, a serial
// division and an output step that is held while out_stall is high.
// A result stays on the out_ ports unchanged while out_stall is high, and no
// new pixel is taken until every result of the current pixel has been moved.
// The cfg_ port (always ready) writes frame width (index 0) or height
// (index 1) and restarts the frame. Reset sets an 8x8 frame and position 0,0;
// the line store needs no clearing since every read entry was written earlier
// in the same frame.
module neighbor_mean_filter_3x3_unit
  import nmf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [10:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [PIXEL_BITS-1:0] in_pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [9:0]                   out_row,
  output logic [9:0]                   out_col,
  output logic signed [23:0]           out_average,
  output logic                         out_last_of_run
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer.
  nmf_ctrl #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  nmf_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_pixel       (in_pixel),
    .cmd            (cmd),
    .status         (status),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_average    (out_average),
    .out_last_of_run(out_last_of_run)
  );

endmodule
